>>> rtl/rhcg_pkg.sv
// Shared types and constants of the rainbow hue chase generator.
// Depends on nothing; used by rhcg_front, rhcg_back and the top level.
package rhcg_pkg;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam int ADDR_W = 8;

   localparam logic [15:0] PERIOD_RESET = 16'd200;
   localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
   localparam logic [2:0]  SECTOR_LAST  = 3'd5;
   localparam logic [5:0]  OFFSET_LAST  = 6'd59;
   localparam logic [6:0]  SECTOR_SPAN  = 7'd60;
   localparam logic [7:0]  CHANNEL_FULL = 8'hFF;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic              is_write;
      logic              is_zero;
      logic              advanced;
      logic [ADDR_W-1:0] addr;
      pixel_type         colour;
   } cmd_type;

   typedef struct packed {
      logic      advanced;
      pixel_type colour;
   } rsp_type;

endpackage

>>> rtl/rhcg_queue.sv
// Small first-in first-out queue of packed words.
// Stand-alone; used between front and back and as the result queue.
module rhcg_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH-1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/rhcg_front.sv
// Front end: period register, tick counter, hue and head pointer; turns each
// accepted word into a strip command. Depends on rhcg_pkg.
module rhcg_front #(
   parameter int LED_COUNT = 144
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [15:0]      csr_step_period_ms,
   input  logic             accept,
   input  logic             mode,
   input  logic [7:0]       pixel_index,
   output rhcg_pkg::cmd_type cmd
);
   import rhcg_pkg::*;

   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [AW:0]   COUNT_EXT = (AW+1)'(LED_COUNT);
   localparam logic [8:0]    COUNT_IDX = 9'(LED_COUNT);
   localparam logic [AW-1:0] HEAD_LAST = AW'(LED_COUNT-1);

   logic [15:0]   period_ff, period_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [2:0]    sector_ff, sector_in;
   logic [5:0]    offset_ff, offset_in;
   logic [AW-1:0] head_ff, head_in;

   logic [15:0]   elapsed_inc;
   logic          is_tick, step, in_range;
   logic [AW:0]   sum, wrap;
   logic [5:0]    base;
   logic [9:0]    prod;
   logic [7:0]    ramp;
   pixel_type     colour;

   assign is_tick = (mode == MODE_TICK);

   always_comb begin
      period_in   = csr_valid ? csr_step_period_ms : period_ff;
      elapsed_in  = elapsed_ff;
      sector_in   = sector_ff;
      offset_in   = offset_ff;
      head_in     = head_ff;
      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      step        = is_tick && (elapsed_inc > period_ff);
      if (accept && is_tick) begin
         elapsed_in = step ? '0 : elapsed_inc;
         if (step) begin
            head_in = (head_ff == '0) ? HEAD_LAST : head_ff - 1'b1;
            if (offset_ff == OFFSET_LAST) begin
               offset_in = '0;
               sector_in = (sector_ff == SECTOR_LAST) ? '0 : sector_ff + 1'b1;
            end else begin
               offset_in = offset_ff + 1'b1;
            end
         end
      end
   end

   // ramp = floor(base * 17 / 4), base counts down in odd sectors
   always_comb begin
      base   = sector_in[0] ? 6'(SECTOR_SPAN - {1'b0, offset_in}) : offset_in;
      prod   = {base, 4'b0000} + {4'b0000, base};
      ramp   = prod[9:2];
      colour = '0;
      unique case (sector_in)
         3'd0: begin
            colour.red   = CHANNEL_FULL;
            colour.green = ramp;
         end
         3'd1: begin
            colour.red   = ramp;
            colour.green = CHANNEL_FULL;
         end
         3'd2: begin
            colour.green = CHANNEL_FULL;
            colour.blue  = ramp;
         end
         3'd3: begin
            colour.green = ramp;
            colour.blue  = CHANNEL_FULL;
         end
         3'd4: begin
            colour.red   = ramp;
            colour.blue  = CHANNEL_FULL;
         end
         default: begin
            colour.red   = CHANNEL_FULL;
            colour.blue  = ramp;
         end
      endcase
   end

   always_comb begin
      in_range = ({1'b0, pixel_index} < COUNT_IDX);
      sum      = {1'b0, head_ff} + {1'b0, pixel_index[AW-1:0]};
      wrap     = (sum >= COUNT_EXT) ? sum - COUNT_EXT : sum;
      cmd.is_write = step;
      cmd.is_zero  = !is_tick && !in_range;
      cmd.advanced = step;
      cmd.colour   = colour;
      priority if (step) begin
         cmd.addr = ADDR_W'(head_in);
      end else if (is_tick) begin
         cmd.addr = ADDR_W'(head_ff);
      end else begin
         cmd.addr = ADDR_W'(wrap[AW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         elapsed_ff <= '0;
         sector_ff  <= '0;
         offset_ff  <= '0;
         head_ff    <= '0;
      end else begin
         period_ff  <= period_in;
         elapsed_ff <= elapsed_in;
         sector_ff  <= sector_in;
         offset_ff  <= offset_in;
         head_ff    <= head_in;
      end
   end

endmodule

>>> rtl/rhcg_back.sv
// Back end: strip memory with written-flags, registered read stage and the
// result queue. Depends on rhcg_pkg and rhcg_queue.
module rhcg_back #(
   parameter int LED_COUNT = 144,
   parameter int OUT_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  rhcg_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              pop,
   output logic              empty,
   output rhcg_pkg::rsp_type rsp
);
   import rhcg_pkg::*;

   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CW = $clog2(OUT_DEPTH+1);
   localparam logic [CW:0] OUT_ROOM = (CW+1)'(OUT_DEPTH);

   logic [23:0]          mem_ff [LED_COUNT];
   logic [LED_COUNT-1:0] written_ff;
   logic                 p_valid_ff;
   cmd_type              p_cmd_ff;
   logic [23:0]          rd_data_ff;
   logic                 hit_ff;

   logic [AW-1:0]        addr;
   logic [CW-1:0]        out_count;
   logic                 out_full;
   logic                 issue;
   rsp_type              result;
   logic [$bits(rsp_type)-1:0] out_rdata;

   assign addr    = cmd.addr[AW-1:0];
   assign issue   = !cmd_empty
                    && (({1'b0, out_count} + (CW+1)'(p_valid_ff)) < OUT_ROOM);
   assign cmd_pop = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= issue;
         if (issue && cmd.is_write) begin
            written_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p_cmd_ff   <= cmd;
         rd_data_ff <= mem_ff[addr];
         hit_ff     <= written_ff[addr];
         if (cmd.is_write) begin
            mem_ff[addr] <= cmd.colour;
         end
      end
   end

   always_comb begin
      result.advanced = p_cmd_ff.advanced;
      priority if (p_cmd_ff.is_write) begin
         result.colour = p_cmd_ff.colour;
      end else if (p_cmd_ff.is_zero || !hit_ff) begin
         result.colour = '0;
      end else begin
         result.colour = pixel_type'(rd_data_ff);
      end
   end

   rhcg_queue #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock(clock),
      .reset(reset),
      .push (p_valid_ff),
      .wdata(result),
      .pop  (pop),
      .rdata(out_rdata),
      .empty(empty),
      .full (out_full),
      .count(out_count)
   );

   assign rsp = rsp_type'(out_rdata);

endmodule

>>> rtl/rainbow_hue_chase_generator.sv
// Rainbow hue chase generator, top level.
// Input words: mode 0 is a one millisecond tick, mode 1 reads a strip pixel.
// A word is taken at a clock edge with push high and full low; every word
// gives exactly one result word, in order.
// Results: while empty is low the oldest word is on rsp_*; pop takes it.
// csr_valid writes step_period_ms; csr_ready is always high. Write only idle.
// A taken word passes the front command queue, the memory read register
// and the result queue before it shows on rsp_*.
// Throughput: one word per cycle while the result queue has room, set by
// the single strip memory port. A tick that steps the hue writes the new
// head colour; the write and any read share that port in command order.
// Reset: period 200, hue 0, counter 0, strip all off, both queues empty.
// When pop stays low the result queue fills, the back end stops draining
// the command queue, and full rises once the command queue is full.
// Depends on rhcg_pkg, rhcg_front, rhcg_queue, rhcg_back.
module rainbow_hue_chase_generator #(
   parameter int LED_COUNT = 144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_step_period_ms,
   input  logic        push,
   output logic        full,
   input  logic        req_mode,
   input  logic [7:0]  req_pixel_index,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_advanced,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);
   import rhcg_pkg::*;

   localparam int CMD_DEPTH = 4;

   cmd_type cmd_front, cmd_back;
   rsp_type rsp;
   logic    accept, cmd_empty, cmd_pop;
   logic [$bits(cmd_type)-1:0]  cmd_rdata;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;

   rhcg_front #(
      .LED_COUNT(LED_COUNT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_step_period_ms(csr_step_period_ms),
      .accept            (accept),
      .mode              (req_mode),
      .pixel_index       (req_pixel_index),
      .cmd               (cmd_front)
   );

   rhcg_queue #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push (accept),
      .wdata(cmd_front),
      .pop  (cmd_pop),
      .rdata(cmd_rdata),
      .empty(cmd_empty),
      .full (full),
      .count(cmd_count)
   );

   assign cmd_back = cmd_type'(cmd_rdata);

   rhcg_back #(
      .LED_COUNT(LED_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd      (cmd_back),
      .cmd_pop  (cmd_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp)
   );

   assign rsp_advanced = rsp.advanced;
   assign rsp_red      = rsp.colour.red;
   assign rsp_green    = rsp.colour.green;
   assign rsp_blue     = rsp.colour.blue;

endmodule

>>> rtl/rhcg_checker.sv
// Port-level checks of the rainbow hue chase generator, bound to the top.
// Depends on rainbow_hue_chase_generator port names only.
module rhcg_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic       rsp_advanced,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_step_saturated: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_advanced) |->
         (rsp_red == 8'hFF || rsp_green == 8'hFF || rsp_blue == 8'hFF))
      else $error("stepped colour has no full channel");

   a_step_one_off: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_advanced) |->
         (rsp_red == 8'h00 || rsp_green == 8'h00 || rsp_blue == 8'h00))
      else $error("stepped colour has no dark channel");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_advanced) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue)))
      else $error("result word changed while stalled");

endmodule

bind rainbow_hue_chase_generator rhcg_checker u_rhcg_checker (.*);

>>> tb/sv/rainbow_hue_chase_generator_test.sv
// Self-checking testbench for rainbow_hue_chase_generator: directed table, then random
// ticks and pixel reads under sender/receiver idling, checked against a built-in predictor.
// Depends on rhcg_pkg and the RTL of the block.
module rainbow_hue_chase_generator_test;
   import rhcg_pkg::*;

   localparam int STRIP_LEN = 144;
   localparam int HUE_LAST = 359;
   localparam rsp_type OFF_PIXEL = '0;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  period;
      logic         mode;
      logic [7:0]   index;
      logic         typed;
      rsp_type      want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_step_period_ms = '0;
   logic        push = 1'b0;
   logic        full;
   logic        req_mode = MODE_TICK;
   logic [7:0]  req_pixel_index = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_advanced;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   rainbow_hue_chase_generator #(.LED_COUNT(STRIP_LEN)) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_step_period_ms (csr_step_period_ms),
      .push               (push),
      .full               (full),
      .req_mode           (req_mode),
      .req_pixel_index    (req_pixel_index),
      .empty              (empty),
      .pop                (pop),
      .rsp_advanced       (rsp_advanced),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // chase state mirror
   logic [15:0] step_period = PERIOD_RESET;
   logic [15:0] tick_count = '0;
   int          hue_deg = 0;
   int          head_slot = 0;
   pixel_type   pixel_store [STRIP_LEN];

   rsp_type     pending_pixels [$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          take_idle_pct = 0;
   int          hold_left = 0;

   plan_row_type directed_plan [21] = '{
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd0,   1'b1, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd143, 1'b1, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd255, 1'b1, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd0,   1'b1, OFF_PIXEL},
      '{ROW_CSR,  16'd0,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd255, 1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd1,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd2,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd144, 1'b1, OFF_PIXEL},
      '{ROW_CSR,  16'd1,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_CSR,  16'hFFFF,  MODE_TICK, 8'd0,   1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'hAA,  1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_TICK, 8'h55,  1'b0, OFF_PIXEL},
      '{ROW_WORD, 16'd0,     MODE_READ, 8'd143, 1'b0, OFF_PIXEL}
   };

   function automatic rsp_type predict_chase(logic mode, logic [7:0] index);
      rsp_type   word;
      pixel_type hue_color;
      int        sector;
      int        offset;
      int        ramp;
      word = '0;
      if (mode == MODE_READ) begin
         if (index < STRIP_LEN)
            word.colour = pixel_store[(head_slot + index) % STRIP_LEN];
         return word;
      end
      if (tick_count != ELAPSED_MAX)
         tick_count = tick_count + 16'd1;
      if (tick_count > step_period) begin
         tick_count = '0;
         hue_deg = (hue_deg >= HUE_LAST) ? 0 : hue_deg + 1;
         head_slot = (head_slot == 0) ? STRIP_LEN - 1 : head_slot - 1;
         sector = hue_deg / 60;
         offset = hue_deg % 60;
         ramp = (sector % 2 == 1) ? ((60 - offset) * 17) / 4 : (offset * 17) / 4;
         hue_color = '0;
         case (sector)
            0: begin
               hue_color.red = CHANNEL_FULL;
               hue_color.green = 8'(ramp);
            end
            1: begin
               hue_color.red = 8'(ramp);
               hue_color.green = CHANNEL_FULL;
            end
            2: begin
               hue_color.green = CHANNEL_FULL;
               hue_color.blue = 8'(ramp);
            end
            3: begin
               hue_color.green = 8'(ramp);
               hue_color.blue = CHANNEL_FULL;
            end
            4: begin
               hue_color.red = 8'(ramp);
               hue_color.blue = CHANNEL_FULL;
            end
            default: begin
               hue_color.red = CHANNEL_FULL;
               hue_color.blue = 8'(ramp);
            end
         endcase
         pixel_store[head_slot] = hue_color;
         word.advanced = 1'b1;
      end
      word.colour = pixel_store[head_slot];
      return word;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_word(input logic mode, input logic [7:0] index, input logic typed,
                            input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_mode <= mode;
      req_pixel_index <= index;
      @(posedge clock);
      while (full)
         @(posedge clock);
      predicted = predict_chase(mode, index);
      pending_pixels.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      int waited;
      push <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         $error("%0d result words never arrived", pending_pixels.size());
         mismatches++;
         pending_pixels.delete();
      end
   endtask

   task automatic write_period(input logic [15:0] period);
      drain_results();
      csr_valid <= 1'b1;
      csr_step_period_ms <= period;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      step_period = period;
   endtask

   task automatic run_random(input int segments, input int words, input int hold);
      logic [15:0] period;
      logic        mode;
      logic [7:0]  index;
      int          pick;
      for (int s = 0; s < segments; s++) begin
         pick = $urandom_range(9);
         if (pick < 4)
            period = '0;
         else if (pick < 7)
            period = 16'($urandom_range(3, 1));
         else if (pick < 9)
            period = 16'($urandom_range(40, 4));
         else
            period = ELAPSED_MAX;
         write_period(period);
         if (s == 0)
            hold_left = hold;
         for (int n = 0; n < words; n++) begin
            mode = ($urandom_range(99) < 35) ? MODE_READ : MODE_TICK;
            pick = $urandom_range(9);
            if (pick < 5)
               index = 8'($urandom_range(15));
            else if (pick < 8)
               index = 8'($urandom_range(STRIP_LEN - 1));
            else
               index = 8'($urandom_range(255));
            send_word(mode, index, 1'b0, OFF_PIXEL);
         end
      end
   endtask

   // result side: check each popped word, then pick pop for the next edge
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               check_field("advanced", {7'd0, want.advanced}, {7'd0, rsp_advanced});
               check_field("red", want.colour.red, rsp_red);
               check_field("green", want.colour.green, rsp_green);
               check_field("blue", want.colour.blue, rsp_blue);
            end
         end
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   initial begin
      int   sweep_words;
      logic top_seen;
      foreach (pixel_store[i])
         pixel_store[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      take_idle_pct = 88;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR)
            write_period(directed_plan[i].period);
         else
            send_word(directed_plan[i].mode, directed_plan[i].index,
                      directed_plan[i].typed, directed_plan[i].want);
      end
      run_random(2, 12, 0);

      send_idle_pct = 88;
      take_idle_pct = 33;
      run_random(2, 12, 0);

      send_idle_pct = 0;
      take_idle_pct = 0;
      run_random(2, 12, 400);

      // hue sweep until it wraps past 359
      write_period('0);
      sweep_words = 0;
      top_seen = 1'b0;
      while (!(top_seen && hue_deg != HUE_LAST)) begin
         if (sweep_words % 16 == 15)
            send_word(MODE_READ, 8'($urandom_range(STRIP_LEN - 1)), 1'b0, OFF_PIXEL);
         else
            send_word(MODE_TICK, 8'($urandom_range(255)), 1'b0, OFF_PIXEL);
         if (hue_deg == HUE_LAST)
            top_seen = 1'b1;
         sweep_words++;
      end

      // longest period: ticks only count
      write_period(ELAPSED_MAX);
      for (int n = 0; n < 8; n++)
         send_word(MODE_TICK, 8'($urandom_range(255)), 1'b0, OFF_PIXEL);
      send_word(MODE_READ, 8'd0, 1'b0, OFF_PIXEL);

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
